### hw/rtl/frac_pkg.sv
// frac_pkg: shared types and constants for the fraction arithmetic unit
// no dependencies
package frac_pkg;

    localparam int RES_WIDTH = 34;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    typedef struct packed {
        logic load;
        logic mul_step;
        logic sum_step;
        logic gcd_start;
        logic div_start;
        logic out_load;
    } frac_cmd_t;

    typedef struct packed {
        logic reduce;
        logic gcd_done;
        logic div_done;
    } frac_stat_t;

endpackage

### hw/rtl/frac_dp.sv
// frac_dp: datapath with operand registers, products, gcd and divide units
// depends on frac_pkg
module frac_dp #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  frac_pkg::frac_cmd_t                    cmd,
    output frac_pkg::frac_stat_t                   stat,
    input  logic [1:0]                             mode,
    input  logic signed [15:0]                     num_a,
    input  logic signed [15:0]                     den_a,
    input  logic signed [15:0]                     num_b,
    input  logic signed [15:0]                     den_b,
    output logic signed [frac_pkg::RES_WIDTH-1:0]  res_num,
    output logic signed [frac_pkg::RES_WIDTH-1:0]  res_den,
    output logic                                   status
);
    localparam int W = frac_pkg::RES_WIDTH;
    localparam int CW = $clog2(W + 1);

    logic [1:0] mode_reg;
    logic signed [OPERAND_WIDTH-1:0] na_reg, da_reg, nb_reg, db_reg;
    logic signed [W-1:0] p1_reg, p2_reg, pd_reg;
    logic signed [W-1:0] rn_reg, rd_reg;
    logic err_reg;
    logic [W-1:0] gx_reg, gy_reg;
    logic [CW-1:0] gk_reg;
    logic gbusy_reg;
    logic [W-1:0] q_reg, rem_reg, dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic dbusy_reg, dsel_reg;
    logic [W-1:0] qn_reg;
    logic signed [W-1:0] out_num_reg, out_den_reg;
    logic out_err_reg;

    logic signed [OPERAND_WIDTH-1:0] m1a, m1b, m2a, m2b;
    logic signed [2*OPERAND_WIDTH-1:0] prod1, prod2, prod3;
    logic signed [W-1:0] sum_next;
    logic [W-1:0] gx_sub, gy_sub;
    logic [W:0] trial;

    function automatic logic signed [OPERAND_WIDTH-1:0] ext(input logic [15:0] v);
        logic [31:0] t;
        t = {16'b0, v};
        return t[OPERAND_WIDTH-1:0];
    endfunction

    always_comb
    begin
        m1a = na_reg;
        m1b = db_reg;
        m2a = nb_reg;
        m2b = da_reg;
        case (mode_reg)
            frac_pkg::OP_MUL:
            begin
                m1b = nb_reg;
                m2a = db_reg;
            end
            frac_pkg::OP_DIV:
            begin
                m2a = nb_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign prod1 = m1a * m1b;
    assign prod2 = m2a * m2b;
    assign prod3 = da_reg * db_reg;
    assign sum_next = (mode_reg == frac_pkg::OP_SUB) ? p1_reg - p2_reg : p1_reg + p2_reg;
    assign gx_sub = gx_reg - gy_reg;
    assign gy_sub = gy_reg - gx_reg;
    assign trial = {rem_reg, q_reg[W-1]} - {1'b0, dvs_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            na_reg <= ext(num_a);
            da_reg <= ext(den_a);
            nb_reg <= ext(num_b);
            db_reg <= ext(den_b);
        end
        if (cmd.mul_step)
        begin
            p1_reg <= W'(prod1);
            if (mode_reg == frac_pkg::OP_MUL || mode_reg == frac_pkg::OP_DIV)
                p2_reg <= W'(prod2);
            else
                p2_reg <= W'(prod2);
            pd_reg <= W'(prod3);
            err_reg <= (mode_reg == frac_pkg::OP_ADD || mode_reg == frac_pkg::OP_SUB)
                       && (da_reg == '0 || db_reg == '0);
        end
        if (cmd.sum_step)
        begin
            if (mode_reg == frac_pkg::OP_ADD || mode_reg == frac_pkg::OP_SUB)
            begin
                rn_reg <= sum_next;
                rd_reg <= pd_reg;
            end
            else
            begin
                rn_reg <= p1_reg;
                rd_reg <= (mode_reg == frac_pkg::OP_MUL) ? pd_reg : p2_reg;
            end
        end
        // binary gcd: strip common twos, halve even sides, halve odd differences
        if (cmd.gcd_start)
        begin
            gx_reg <= rn_reg;
            gy_reg <= rd_reg;
            gk_reg <= '0;
        end
        else if (gbusy_reg && gx_reg != gy_reg)
        begin
            case ({gx_reg[0], gy_reg[0]})
                2'b00:
                begin
                    gx_reg <= {1'b0, gx_reg[W-1:1]};
                    gy_reg <= {1'b0, gy_reg[W-1:1]};
                    gk_reg <= gk_reg + 1'b1;
                end
                2'b01:
                    gx_reg <= {1'b0, gx_reg[W-1:1]};
                2'b10:
                    gy_reg <= {1'b0, gy_reg[W-1:1]};
                default:
                begin
                    if (gx_reg > gy_reg)
                        gx_reg <= {1'b0, gx_sub[W-1:1]};
                    else
                        gy_reg <= {1'b0, gy_sub[W-1:1]};
                end
            endcase
        end
        if (cmd.div_start)
        begin
            q_reg <= rn_reg;
            rem_reg <= '0;
            dvs_reg <= gx_reg << gk_reg;
            dsel_reg <= 1'b0;
        end
        else if (dbusy_reg && cnt_reg == '0 && !dsel_reg)
        begin
            qn_reg <= q_reg;
            q_reg <= rd_reg;
            rem_reg <= '0;
            dsel_reg <= 1'b1;
        end
        else if (dbusy_reg && cnt_reg != '0)
        begin
            if (!trial[W])
            begin
                rem_reg <= trial[W-1:0];
                q_reg <= {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[W-2:0], q_reg[W-1]};
                q_reg <= {q_reg[W-2:0], 1'b0};
            end
        end
        if (cmd.out_load)
        begin
            out_err_reg <= err_reg;
            if (err_reg)
            begin
                out_num_reg <= '0;
                out_den_reg <= '0;
            end
            else if (stat.reduce)
            begin
                out_num_reg <= qn_reg;
                out_den_reg <= q_reg;
            end
            else
            begin
                out_num_reg <= rn_reg;
                out_den_reg <= rd_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gbusy_reg <= 1'b0;
            dbusy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            if (cmd.gcd_start)
                gbusy_reg <= 1'b1;
            else if (gbusy_reg && gx_reg == gy_reg)
                gbusy_reg <= 1'b0;
            if (cmd.div_start)
            begin
                dbusy_reg <= 1'b1;
                cnt_reg <= CW'(W);
            end
            else if (dbusy_reg)
            begin
                if (cnt_reg != '0)
                    cnt_reg <= cnt_reg - 1'b1;
                else if (!dsel_reg)
                    cnt_reg <= CW'(W);
                else
                    dbusy_reg <= 1'b0;
            end
        end
    end

    assign stat.reduce = !err_reg && (mode_reg == frac_pkg::OP_ADD || mode_reg == frac_pkg::OP_SUB)
                         && rn_reg > 0 && rd_reg > 0;
    assign stat.gcd_done = gbusy_reg && gx_reg == gy_reg;
    assign stat.div_done = dbusy_reg && dsel_reg && cnt_reg == '0;

    assign res_num = out_num_reg;
    assign res_den = out_den_reg;
    assign status = out_err_reg;

    property p_div_not_gcd;
        @(posedge clk) disable iff (!rst_n) dbusy_reg |-> !gbusy_reg;
    endproperty
    a_div_not_gcd: assert property (p_div_not_gcd) else $error("divide overlaps gcd");

    property p_gcd_start_idle;
        @(posedge clk) disable iff (!rst_n) cmd.gcd_start |-> !gbusy_reg && !dbusy_reg;
    endproperty
    a_gcd_start_idle: assert property (p_gcd_start_idle) else $error("gcd restarted");

    property p_cnt_bound;
        @(posedge clk) disable iff (!rst_n) cnt_reg <= CW'(W);
    endproperty
    a_cnt_bound: assert property (p_cnt_bound) else $error("divide count overflow");

endmodule

### hw/rtl/frac_ctrl.sv
// frac_ctrl: sequencer for the fraction unit handshake and datapath steps
// depends on frac_pkg
module frac_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  frac_pkg::frac_stat_t stat,
    output frac_pkg::frac_cmd_t  cmd
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_SUM  = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_GCD  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_OUT  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic accept;

    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = accept;
                if (accept)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_step = 1'b1;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (stat.reduce)
                begin
                    cmd.gcd_start = 1'b1;
                    state_next = S_GCD;
                end
                else
                    state_next = S_OUT;
            end
            S_GCD:
            begin
                if (stat.gcd_done)
                begin
                    cmd.div_start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    property p_load_idle;
        @(posedge clk) disable iff (!rst_n) cmd.load |=> state_reg == S_MUL;
    endproperty
    a_load_idle: assert property (p_load_idle) else $error("load did not start work");

    property p_out_sets_valid;
        @(posedge clk) disable iff (!rst_n) cmd.out_load |=> out_valid_reg;
    endproperty
    a_out_sets_valid: assert property (p_out_sets_valid) else $error("result beat lost");

    property p_no_overwrite;
        @(posedge clk) disable iff (!rst_n) (out_valid_reg && out_stall) |-> !cmd.out_load;
    endproperty
    a_no_overwrite: assert property (p_no_overwrite) else $error("stalled beat overwritten");

endmodule

### hw/rtl/fraction_arithmetic_unit_top.sv
// fraction arithmetic unit top: one beat at a time, input stalled until the sequencer is idle
// mul, div and unreduced add/sub: load, product and sum steps and a check, then output
// reduced add/sub (numerator and denominator positive): binary gcd and divide steps before output
// next beat accepted after the result is registered; output register frees the input
// rst_n asynchronous active low clears the sequencer, the output valid flag and the busy flags
// depends on frac_pkg, frac_ctrl, frac_dp
module fraction_arithmetic_unit_top #(
    parameter int OPERAND_WIDTH = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [1:0]                            mode,
    input  logic signed [15:0]                    num_a,
    input  logic signed [15:0]                    den_a,
    input  logic signed [15:0]                    num_b,
    input  logic signed [15:0]                    den_b,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [frac_pkg::RES_WIDTH-1:0] res_num,
    output logic signed [frac_pkg::RES_WIDTH-1:0] res_den,
    output logic                                  status
);
    frac_pkg::frac_cmd_t  cmd;
    frac_pkg::frac_stat_t stat;

    frac_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    frac_dp #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .mode    (mode),
        .num_a   (num_a),
        .den_a   (den_a),
        .num_b   (num_b),
        .den_b   (den_b),
        .res_num (res_num),
        .res_den (res_den),
        .status  (status)
    );

endmodule
